// File: src/dstm_pkg.sv
// Shared types and constants for the distortion shaper with tone filter and mix.
// Holds register codes, shaper modes, sequencer states and fixed-point widths.
// No dependencies; every other file but src/dstm_checker.sv imports this package.
package dstm_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned DRIVE_W  = 13;
  localparam int unsigned MAKEUP_W = 16;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned WET_W    = 17;
  localparam int unsigned MODE_W   = 2;

  localparam int unsigned MUL_B_W   = 17;
  localparam int unsigned TANH_W    = 31;
  localparam int unsigned TANH_FRAC = 30;

  localparam int unsigned DRIVE_SHIFT  = 8;
  localparam int unsigned MAKEUP_SHIFT = 15;
  localparam int unsigned ALPHA_SHIFT  = 16;
  localparam int unsigned MIX_SHIFT    = 16;

  localparam logic [WET_W-1:0] WET_ONE = 17'h10000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DRIVE  = 8'd0,
    CFG_MAKEUP = 8'd1,
    CFG_ALPHA  = 8'd2,
    CFG_WET    = 8'd3,
    CFG_MODE   = 8'd4,
    CFG_BYPASS = 8'd5
  } cfg_index_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SOFT = 2'd0,
    MODE_HARD = 2'd1,
    MODE_FOLD = 2'd2
  } shaper_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRIVE,
    ST_SHAPE,
    ST_POS,
    ST_LOOKUP,
    ST_FRAC_LO,
    ST_FRAC_HI,
    ST_INTERP,
    ST_MAKEUP,
    ST_FILTER,
    ST_UPDATE,
    ST_MIX_WET,
    ST_MIX_SUM,
    ST_EMIT
  } dstm_state_e;

  typedef struct packed {
    logic [DRIVE_W-1:0]  drive_gain;
    logic [MAKEUP_W-1:0] makeup_gain;
    logic [ALPHA_W-1:0]  tone_alpha;
    logic [WET_W-1:0]    wet_mix;
    logic [MODE_W-1:0]   shaper_mode;
    logic                bypass;
  } dstm_cfg_t;

  localparam dstm_cfg_t CFG_RST = '{
    drive_gain:  13'd256,
    makeup_gain: 16'h8000,
    tone_alpha:  16'h8000,
    wet_mix:     17'h10000,
    shaper_mode: MODE_SOFT,
    bypass:      1'b0
  };

endpackage

// File: src/dstm_if.sv
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on dstm_pkg for the register port widths.
interface dstm_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink (input valid, input sample_in, input channel, output ready);
endinterface

interface dstm_result_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface dstm_cfg_if import dstm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/distortion_shaper_tone_mix_top.sv
// Distortion shaper with per-channel one-pole tone filter and dry/wet mix.
// Channels: cfg_i (register writes, always ready), in_i (sample and channel),
// out_o (processed sample). Every channel moves one transfer when valid and
// ready are both high. The user must write registers only while the block is
// idle; the block itself does not enforce this. One sequencer drives a single
// shared multiplier, one product per cycle; that multiplier sets the rate.
// Bypass goes straight to emit; hard or fold runs drive, shape, makeup, filter,
// update, mix wet, mix sum and emit; soft adds table position, lookup and a
// two-part interpolation product. A new sample is taken in the idle state
// after the result enters the output register, which holds a finished result
// while the receiver stalls; the next sample is accepted and computed
// meanwhile and waits in its final step until the output register frees.
// Reset (rst_ni low, asynchronous) restores the register defaults, clears
// both filter states and empties the output; the tanh table is constant, so
// no start-up pass is needed.
// Depends on dstm_pkg, dstm_if, dstm_mul and dstm_tanh_rom.
module distortion_shaper_tone_mix_top import dstm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH     = 24,
  parameter int unsigned TANH_TABLE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dstm_cfg_if.sink      cfg_i,
  dstm_sample_if.sink   in_i,
  dstm_result_if.source out_o
);

  localparam int unsigned W      = SAMPLE_WIDTH;
  localparam int unsigned MA     = (W + 6 > 32) ? W + 6 : 32;
  localparam int unsigned P      = MA + MUL_B_W + 1;
  localparam int unsigned SW     = P + MUL_B_W + 1;
  localparam int unsigned KW     = W + 6;
  localparam int unsigned YW     = W + 2;
  localparam int unsigned FW     = W + 3;
  localparam int unsigned MW     = W + 4;
  localparam int unsigned TW     = TANH_W + 3;
  localparam int unsigned POS_SH = W + 2;
  localparam int unsigned IW     = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int unsigned LSH    = (W > 31) ? W - 31 : 0;
  localparam int unsigned RSH    = (W < 31) ? 31 - W : 0;

  localparam logic signed [KW-1:0] K_ONE   = KW'(1) << (W - 1);
  localparam logic signed [KW-1:0] K_TWO   = K_ONE <<< 1;
  localparam logic signed [KW-1:0] K_THREE = K_TWO + K_ONE;
  localparam logic signed [KW-1:0] K_MASK  = (K_ONE <<< 2) - KW'(1);
  localparam logic signed [P-1:0]  P_MAX   = (P'(1) << (W - 1)) - 1;
  localparam logic signed [P-1:0]  P_MIN   = -(P'(1) << (W - 1));

  dstm_state_e state_q, state_d;
  dstm_cfg_t   cfg_q, cfg_d;

  logic signed [W-1:0]    x_q, x_d;
  logic                   ch_q, ch_d;
  logic                   neg_q, neg_d;
  logic signed [YW-1:0]   y_q, y_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic                   over_q, over_d;
  logic [POS_SH-1:0]      frac_q, frac_d;
  logic signed [P-1:0]    acc_q, acc_d;
  logic signed [W-1:0]    r_q, r_d;
  logic signed [FW-1:0]   left_q, left_d;
  logic signed [FW-1:0]   right_q, right_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [W-1:0]    out_data_q, out_data_d;

  logic                   in_ready;
  logic                   mul_en;
  logic signed [MA-1:0]   mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic signed [P-1:0]    prod_q;
  logic                   rom_en;
  logic [TANH_W-1:0]      rom_base;
  logic signed [TANH_W:0] rom_diff;

  logic signed [KW-1:0]   drv_k;
  logic signed [KW-1:0]   drv_abs;
  logic signed [KW-1:0]   hard_k;
  logic signed [KW-1:0]   fold_t;
  logic signed [KW-1:0]   fold_k;
  logic [P-1:0]           pos_idx;
  logic                   pos_over;
  logic signed [SW-1:0]   frac_sum;
  logic signed [TW-1:0]   tanh_val;
  logic signed [TW:0]     tanh_sc;
  logic signed [FW-1:0]   s_sel;
  logic signed [MW-1:0]   filt_err;
  logic signed [FW-1:0]   s_new;
  logic [WET_W-1:0]       wet_eff;
  logic [WET_W-1:0]       dry;
  logic signed [P-1:0]    mix_res;

  dstm_mul #(.A_W(MA)) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_q)
  );

  dstm_tanh_rom #(.DEPTH(TANH_TABLE_DEPTH)) u_tanh_rom (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .idx_i  (idx_q),
    .over_i (over_q),
    .base_o (rom_base),
    .diff_o (rom_diff)
  );

  assign drv_k   = KW'(prod_q >>> DRIVE_SHIFT);
  assign drv_abs = drv_k[KW-1] ? -drv_k : drv_k;
  assign hard_k  = (drv_k > K_ONE) ? K_ONE : ((drv_k < -K_ONE) ? -K_ONE : drv_k);
  assign fold_t  = (drv_k + K_ONE) & K_MASK;
  assign fold_k  = (fold_t <= K_TWO) ? fold_t - K_ONE : K_THREE - fold_t;

  assign pos_idx  = prod_q >> POS_SH;
  assign pos_over = pos_idx >= P'(TANH_TABLE_DEPTH);

  assign frac_sum = (SW'(prod_q) <<< MUL_B_W) + SW'(acc_q);
  assign tanh_val = TW'($signed({1'b0, rom_base})) + TW'(frac_sum >>> POS_SH);
  assign tanh_sc  = ((TW + 1)'(tanh_val) <<< LSH) >>> RSH;

  assign s_sel    = ch_q ? right_q : left_q;
  assign filt_err = MW'(prod_q >>> MAKEUP_SHIFT) - MW'(s_sel);
  assign s_new    = s_sel + FW'(prod_q >>> ALPHA_SHIFT);

  assign wet_eff = (cfg_q.wet_mix > WET_ONE) ? WET_ONE : cfg_q.wet_mix;
  assign dry     = WET_ONE - wet_eff;
  assign mix_res = (prod_q + acc_q) >>> MIX_SHIFT;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_DRIVE:  cfg_d.drive_gain  = cfg_i.data[DRIVE_W-1:0];
        CFG_MAKEUP: cfg_d.makeup_gain = cfg_i.data[MAKEUP_W-1:0];
        CFG_ALPHA:  cfg_d.tone_alpha  = cfg_i.data[ALPHA_W-1:0];
        CFG_WET:    cfg_d.wet_mix     = cfg_i.data[WET_W-1:0];
        CFG_MODE:   cfg_d.shaper_mode = cfg_i.data[MODE_W-1:0];
        CFG_BYPASS: cfg_d.bypass      = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    ch_d        = ch_q;
    neg_d       = neg_q;
    y_d         = y_q;
    idx_d       = idx_q;
    over_d      = over_q;
    frac_d      = frac_q;
    acc_d       = acc_q;
    r_d         = r_q;
    left_d      = left_q;
    right_d     = right_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    in_ready    = 1'b0;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rom_en      = 1'b0;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          x_d     = in_i.sample_in;
          ch_d    = in_i.channel;
          r_d     = in_i.sample_in;
          state_d = cfg_q.bypass ? ST_EMIT : ST_DRIVE;
        end
      end
      ST_DRIVE: begin
        mul_en  = 1'b1;
        mul_a   = MA'(x_q);
        mul_b   = MUL_B_W'(cfg_q.drive_gain);
        state_d = ST_SHAPE;
      end
      ST_SHAPE: begin
        neg_d = drv_k[KW-1];
        if (cfg_q.shaper_mode == MODE_HARD) begin
          y_d     = YW'(hard_k);
          state_d = ST_MAKEUP;
        end else if (cfg_q.shaper_mode == MODE_FOLD) begin
          y_d     = YW'(fold_k);
          state_d = ST_MAKEUP;
        end else begin
          mul_en  = 1'b1;
          mul_a   = MA'(drv_abs);
          mul_b   = MUL_B_W'(TANH_TABLE_DEPTH);
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        over_d  = pos_over;
        idx_d   = pos_over ? IW'(TANH_TABLE_DEPTH) : pos_idx[IW-1:0];
        frac_d  = prod_q[POS_SH-1:0];
        state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        rom_en  = 1'b1;
        state_d = ST_FRAC_LO;
      end
      ST_FRAC_LO: begin
        mul_en  = 1'b1;
        mul_a   = MA'(rom_diff);
        mul_b   = frac_q[MUL_B_W-1:0];
        state_d = ST_FRAC_HI;
      end
      ST_FRAC_HI: begin
        acc_d   = prod_q;
        mul_en  = 1'b1;
        mul_a   = MA'(rom_diff);
        mul_b   = MUL_B_W'(frac_q[POS_SH-1:MUL_B_W]);
        state_d = ST_INTERP;
      end
      ST_INTERP: begin
        y_d     = neg_q ? YW'(-tanh_sc) : YW'(tanh_sc);
        state_d = ST_MAKEUP;
      end
      ST_MAKEUP: begin
        mul_en  = 1'b1;
        mul_a   = MA'(y_q);
        mul_b   = MUL_B_W'(cfg_q.makeup_gain);
        state_d = ST_FILTER;
      end
      ST_FILTER: begin
        mul_en  = 1'b1;
        mul_a   = MA'(filt_err);
        mul_b   = MUL_B_W'(cfg_q.tone_alpha);
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (ch_q) begin
          right_d = s_new;
        end else begin
          left_d = s_new;
        end
        mul_en  = 1'b1;
        mul_a   = MA'(x_q);
        mul_b   = dry;
        state_d = ST_MIX_WET;
      end
      ST_MIX_WET: begin
        acc_d   = prod_q;
        mul_en  = 1'b1;
        mul_a   = MA'(s_sel);
        mul_b   = wet_eff;
        state_d = ST_MIX_SUM;
      end
      ST_MIX_SUM: begin
        if (mix_res > P_MAX) begin
          r_d = W'(P_MAX);
        end else if (mix_res < P_MIN) begin
          r_d = W'(P_MIN);
        end else begin
          r_d = W'(mix_res);
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = r_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RST;
      left_q      <= '0;
      right_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      left_q      <= left_d;
      right_q     <= right_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    ch_q       <= ch_d;
    neg_q      <= neg_d;
    y_q        <= y_d;
    idx_q      <= idx_d;
    over_q     <= over_d;
    frac_q     <= frac_d;
    acc_q      <= acc_d;
    r_q        <= r_d;
    out_data_q <= out_data_d;
  end

  assign cfg_i.ready      = 1'b1;
  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

// File: src/dstm_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on dstm_pkg for the unsigned operand width.
module dstm_mul import dstm_pkg::*; #(
  parameter int unsigned A_W = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [A_W-1:0]        a_i,
  input  logic        [MUL_B_W-1:0]    b_i,
  output logic signed [A_W+MUL_B_W:0]  prod_o
);

  logic signed [A_W+MUL_B_W:0] prod_d;
  logic signed [A_W+MUL_B_W:0] prod_q;

  assign prod_d = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: src/dstm_tanh_rom.sv
// Constant tanh table in Q0.30 over [0, 8], built at elaboration, with a
// registered read of one entry and its difference to the next.
// Depends on dstm_pkg for entry width and fraction bits.
module dstm_tanh_rom import dstm_pkg::*; #(
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned IW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [IW-1:0]            idx_i,
  input  logic                     over_i,
  output logic [TANH_W-1:0]        base_o,
  output logic signed [TANH_W:0]   diff_o
);

  localparam longint Q30          = 64'sd1 << TANH_FRAC;
  localparam int     TAYLOR_TERMS = 24;

  function automatic longint udiv(longint dividend, longint divisor);
    longint quo;
    longint rem;
    int     bt;
    quo = 0;
    rem = 0;
    for (bt = 62; bt >= 0; bt--) begin
      rem = (rem << 1) | ((dividend >> bt) & 64'sd1);
      quo = quo << 1;
      if (rem >= divisor) begin
        rem = rem - divisor;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  function automatic longint exp_neg(longint f);
    longint sum;
    longint term;
    int     n;
    sum  = Q30;
    term = Q30;
    for (n = 1; n <= TAYLOR_TERMS; n++) begin
      term = udiv((term * f) >> TANH_FRAC, longint'(n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [TANH_W-1:0] tanh_entry(int unsigned i);
    longint w;
    longint k;
    longint e;
    longint e1;
    longint den;
    longint num;
    longint j;
    e1 = exp_neg(Q30);
    w  = udiv((64'sd16 << TANH_FRAC) * longint'(i), longint'(DEPTH));
    k  = w >> TANH_FRAC;
    e  = exp_neg(w & (Q30 - 1));
    for (j = 0; j < k; j++) begin
      e = (e * e1 + (Q30 >> 1)) >> TANH_FRAC;
    end
    den = Q30 + e;
    num = ((Q30 - e) << TANH_FRAC) + (den >> 1);
    return TANH_W'(udiv(num, den));
  endfunction

  logic [TANH_W-1:0] tab [DEPTH+1];

  for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
    localparam logic [TANH_W-1:0] ENTRY = tanh_entry(g);
    assign tab[g] = ENTRY;
  end

  logic [IW-1:0]          nxt_idx;
  logic [TANH_W-1:0]      base_q;
  logic signed [TANH_W:0] diff_q;

  assign nxt_idx = over_i ? idx_i : idx_i + 1'b1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= tab[idx_i];
      diff_q <= $signed({1'b0, tab[nxt_idx]}) - $signed({1'b0, tab[idx_i]});
    end
  end

  assign base_o = base_q;
  assign diff_o = diff_q;

endmodule

// File: src/dstm_checker.sv
// Port-level assertions for the distortion shaper top level, with the bind
// that attaches them. Depends only on the top level's channel ports.
module dstm_port_checker #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_sample_i
);

  logic [1:0] pend_q, pend_d;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;
  assign pend_d   = pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_busy_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready while a sample is in progress");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("stalled result dropped or changed");

  a_result_has_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result offered without a pending input");

  a_ready_limits_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pend_q < 2'd2)
    else $error("input ready with two samples outstanding");

endmodule

bind distortion_shaper_tone_mix_top dstm_port_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_dstm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);

// File: tb/sv/dstm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the distortion shaper: tracks register writes, predicts each
// processed sample from its own tanh table, filter state and mix, and compares.
// Depends on dstm_pkg and the channel interfaces in dstm_if.
module dstm_checker import dstm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH     = 24,
  parameter int unsigned TANH_TABLE_DEPTH = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dstm_cfg_if    cfg_i,
  dstm_sample_if in_i,
  dstm_result_if out_i,
  output int     fails_o,
  output int     pending_o,
  output int     checked_o
);

  localparam int     SW        = SAMPLE_WIDTH;
  localparam longint LUT_N     = TANH_TABLE_DEPTH;
  localparam longint UNIT      = longint'(1) << (SW - 1);
  localparam longint Q30       = longint'(1) << TANH_FRAC;
  localparam int     POS_SHIFT = SW - 1 + 3;
  localparam longint MIX_UNITY = 65536;

  typedef logic signed [SW-1:0] sample_t;

  longint    tanh_lut [0:TANH_TABLE_DEPTH];
  longint    tone_state [2];
  dstm_cfg_t regs;
  sample_t   expected_q [$];

  function automatic longint exp_series(longint f);
    longint acc, term;
    int n;
    acc  = Q30;
    term = Q30;
    for (n = 1; n <= 24; n++) begin
      term = ((term * f) >>> TANH_FRAC) / n;
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic void build_lut();
    longint e_unit, pos, e, den;
    longint i, j;
    e_unit = exp_series(Q30);
    for (i = 0; i <= LUT_N; i++) begin
      pos = ((longint'(16) << TANH_FRAC) * i) / LUT_N;
      e   = exp_series(pos & (Q30 - 1));
      for (j = 0; j < (pos >>> TANH_FRAC); j++)
        e = (e * e_unit + (Q30 >>> 1)) >>> TANH_FRAC;
      den = Q30 + e;
      tanh_lut[i] = (((Q30 - e) <<< TANH_FRAC) + den / 2) / den;
    end
  endfunction

  function automatic longint soft_curve(longint d);
    longint mag, p, idx, frac, t, y;
    mag  = (d < 0) ? -d : d;
    p    = mag * LUT_N;
    idx  = p >>> POS_SHIFT;
    frac = p & ((longint'(1) << POS_SHIFT) - 1);
    if (idx >= LUT_N) t = tanh_lut[LUT_N];
    else t = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * frac) >>> POS_SHIFT);
    y = (t * UNIT) >>> TANH_FRAC;
    return (d < 0) ? -y : y;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  function automatic sample_t shape_and_mix(sample_t smp, logic ch);
    longint x, d, y, t, m, acc, w, r, drv, mk, al;
    x = smp;
    if (regs.bypass) return smp;
    drv = regs.drive_gain;
    d   = (x * drv) >>> DRIVE_SHIFT;
    case (regs.shaper_mode)
      MODE_HARD: y = clip_unit(d);
      MODE_FOLD: begin
        t = (d + UNIT) % (4 * UNIT);
        if (t < 0) t = t + 4 * UNIT;
        y = clip_unit((t <= 2 * UNIT) ? t - UNIT : 3 * UNIT - t);
      end
      default: y = soft_curve(d);
    endcase
    mk  = regs.makeup_gain;
    m   = (y * mk) >>> MAKEUP_SHIFT;
    al  = regs.tone_alpha;
    acc = tone_state[ch];
    acc = acc + ((al * (m - acc)) >>> ALPHA_SHIFT);
    tone_state[ch] = acc;
    w = regs.wet_mix;
    if (w > MIX_UNITY) w = MIX_UNITY;
    r = (x * (MIX_UNITY - w) + acc * w) >>> MIX_SHIFT;
    if (r > UNIT - 1) r = UNIT - 1;
    if (r < -UNIT) r = -UNIT;
    return r[SW-1:0];
  endfunction

  initial begin
    build_lut();
    regs       = CFG_RST;
    tone_state = '{0, 0};
    fails_o    = 0;
    pending_o  = 0;
    checked_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      regs       = CFG_RST;
      tone_state = '{0, 0};
      expected_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("sample_out: no result expected, actual %0d", out_i.sample_out);
          fails_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (out_i.sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, out_i.sample_out);
            fails_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_DRIVE:  regs.drive_gain  = cfg_i.data[DRIVE_W-1:0];
          CFG_MAKEUP: regs.makeup_gain = cfg_i.data[MAKEUP_W-1:0];
          CFG_ALPHA:  regs.tone_alpha  = cfg_i.data[ALPHA_W-1:0];
          CFG_WET:    regs.wet_mix     = cfg_i.data[WET_W-1:0];
          CFG_MODE:   regs.shaper_mode = cfg_i.data[MODE_W-1:0];
          CFG_BYPASS: regs.bypass      = cfg_i.data[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready)
        expected_q.push_back(shape_and_mix(in_i.sample_in, in_i.channel));
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the distortion shaper bench: clock, reset, register programming,
// sample stimulus and output backpressure; verdict from dstm_checker.
// Depends on dstm_pkg, dstm_if, distortion_shaper_tone_mix_top and dstm_checker.
module tb_top;
  import dstm_pkg::*;

  localparam int unsigned SW       = 24;
  localparam int unsigned N_PHASES = 22;
  localparam int unsigned N_ITEMS  = 52;
  localparam int unsigned LONG_HOLD = 80;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 8'hFF;
  localparam logic [MODE_W-1:0]      MODE_SPARE    = 2'd3;

  localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

  logic clk;
  logic rst_n;
  logic gaps_on;
  int   hold_req;
  int   fails, pending, checked;
  int   n_sent, n_settings;

  dstm_cfg_if               cfg_bus ();
  dstm_sample_if #(.SAMPLE_WIDTH(SW)) smp_bus ();
  dstm_result_if #(.SAMPLE_WIDTH(SW)) res_bus ();

  distortion_shaper_tone_mix_top #(.SAMPLE_WIDTH(SW)) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (smp_bus),
    .out_o  (res_bus)
  );

  dstm_checker #(.SAMPLE_WIDTH(SW)) u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_i     (cfg_bus),
    .in_i      (smp_bus),
    .out_i     (res_bus),
    .fails_o   (fails),
    .pending_o (pending),
    .checked_o (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // output backpressure, with a long hold on request
  initial begin
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (gaps_on) begin
        res_bus.ready <= ($urandom_range(99) >= 25);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] smp, input logic ch);
    while (gaps_on && $urandom_range(99) < 25) begin
      @(negedge clk);
      smp_bus.valid <= 1'b0;
    end
    @(negedge clk);
    smp_bus.valid     <= 1'b1;
    smp_bus.sample_in <= smp;
    smp_bus.channel   <= ch;
    do @(posedge clk); while (!smp_bus.ready);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    smp_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] drv, mk, al, wt, md, bp);
    wait_drained();
    cfg_write(CFG_DRIVE, drv);
    cfg_write(CFG_MAKEUP, mk);
    cfg_write(CFG_ALPHA, al);
    cfg_write(CFG_WET, wt);
    cfg_write(CFG_MODE, md);
    cfg_write(CFG_BYPASS, bp);
    n_settings++;
  endtask

  // set junk above the register width now and then
  function automatic logic [CFG_DATA_W-1:0] widen(input logic [CFG_DATA_W-1:0] v,
                                                  input int unsigned w);
    if ($urandom_range(4) == 0) return v | ($urandom() << w);
    return v;
  endfunction

  task automatic random_regs();
    logic [CFG_DATA_W-1:0] drv, mk, al, wt, md, bp;
    case ($urandom_range(4))
      0: drv = 256;
      1: drv = 6144;
      2: drv = 0;
      3: drv = 8191;
      default: drv = $urandom_range(8191);
    endcase
    case ($urandom_range(3))
      0: mk = 0;
      1: mk = 32768;
      2: mk = 65535;
      default: mk = $urandom_range(65535);
    endcase
    case ($urandom_range(3))
      0: al = 0;
      1: al = 65535;
      2: al = 32768;
      default: al = $urandom_range(65535);
    endcase
    case ($urandom_range(3))
      0: wt = 0;
      1: wt = 65536;
      2: wt = 131071;
      default: wt = $urandom_range(131071);
    endcase
    md = $urandom_range(3);
    bp = ($urandom_range(99) < 15);
    set_regs(widen(drv, DRIVE_W), widen(mk, MAKEUP_W), widen(al, ALPHA_W),
             widen(wt, WET_W), widen(md, MODE_W), widen(bp, 1));
    if ($urandom_range(3) == 0) cfg_write(CFG_UNUSED_LO + $urandom_range(249), $urandom());
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1: return SW'($signed($urandom_range(2000)) - 1000);
      2: return SW'($signed($urandom_range(1 << 21)) - (1 << 20));
      default: return SW'($urandom());
    endcase
  endfunction

  initial begin
    int ph, k;
    rst_n             = 1'b0;
    gaps_on           = 1'b1;
    hold_req          = 0;
    n_sent            = 0;
    n_settings        = 0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    smp_bus.valid     = 1'b0;
    smp_bus.sample_in = '0;
    smp_bus.channel   = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: soft, unity drive, full wet
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    // hard clip, drive beyond range given with junk upper bits, wet above one
    set_regs('1, 32'd65535, 32'd65535, 32'd131071, 32'(MODE_HARD), 32'd0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    set_regs(32'd8191, 32'd65535, 32'd65535, 32'd65536, 32'(MODE_FOLD), 32'd0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(24'sd12345, 1'b0);
    // spare mode code, magnitudes past the end of the tanh table
    set_regs(32'd8191, 32'd32768, 32'd32768, 32'd65536, 32'(MODE_SPARE), 32'd0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(24'sd300000, 1'b0);
    set_regs(32'd0, 32'd32768, 32'd32768, 32'd32768, 32'(MODE_FOLD), 32'd0);
    send_sample(S_MAX, 1'b1);
    wait_drained();
    cfg_write(CFG_UNUSED_LO, '1);
    cfg_write(CFG_UNUSED_HI, 32'd5);
    send_sample(S_MIN, 1'b0);
    set_regs(32'd6144, 32'd0, 32'd0, 32'd0, 32'(MODE_SOFT), 32'd1);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b0);
    set_regs(32'd6144, 32'd0, 32'd0, 32'd0, 32'(MODE_HARD), 32'd0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);

    for (ph = 0; ph < N_PHASES; ph++) begin
      random_regs();
      gaps_on = !(ph >= 8 && ph < 12);
      for (k = 0; k < N_ITEMS; k++) begin
        if ((ph == 5 || ph == 16) && k == 20) hold_req++;
        send_sample(rand_sample(), 1'($urandom()));
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Covered %0d samples over %0d register settings: every mode code, bypass,",
             n_sent, n_settings);
    $display("gain and mix extremes, both channels, long output stalls; %0d results checked",
             checked);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
